### rtl/dvdd_pkg.sv
// Shared types, codes and constant tables for the date check / day difference block.
// No dependencies; imported by the lane, merge and top modules.
package dvdd_pkg;

  localparam int YEAR_W = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W = 5;
  localparam int STAT_W = 2;
  localparam int DNUM_W = 24;
  localparam int DIFF_W = 25;
  localparam int OUT_DIFF_W = 23;
  localparam int CFG_IDX_W = 1;

  // floor(x/25) = (x * RECIP_25) >> RECIP_SHIFT for x below 2^14
  localparam logic [12:0] RECIP_25 = 13'd5243;
  localparam int RECIP_SHIFT = 17;

  localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
  localparam logic [STAT_W-1:0] STAT_YEAR = 2'd1;
  localparam logic [STAT_W-1:0] STAT_MONTH = 2'd2;
  localparam logic [STAT_W-1:0] STAT_DAY = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_LOWEST_YEAR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_YEAR = 1'd1;

  localparam logic [YEAR_W-1:0] LOWEST_YEAR_RST = 14'd1500;
  localparam logic [YEAR_W-1:0] CURRENT_YEAR_RST = 14'd2023;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DNUM_W-1:0] dnum;
  } lane_res_t;

  // Days in month for valid months, non-leap
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                            len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:         len = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      default:                         len = 5'd0;
    endcase
    return len;
  endfunction

  // (153*m' - 457)/5 with months below 3 moved to 12..14 of the prior year
  function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [8:0] off;
    case (m)
      4'd0:    off = 9'd275;
      4'd1:    off = 9'd306;
      4'd2:    off = 9'd337;
      4'd3:    off = 9'd0;
      4'd4:    off = 9'd31;
      4'd5:    off = 9'd61;
      4'd6:    off = 9'd92;
      4'd7:    off = 9'd122;
      4'd8:    off = 9'd153;
      4'd9:    off = 9'd184;
      4'd10:   off = 9'd214;
      4'd11:   off = 9'd245;
      4'd12:   off = 9'd275;
      4'd13:   off = 9'd306;
      4'd14:   off = 9'd337;
      default: off = 9'd367;
    endcase
    return off;
  endfunction

endpackage

### rtl/dvdd_lane.sv
// One date lane: two-stage validation and day number conversion.
// Depends on dvdd_pkg.
module dvdd_lane import dvdd_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [YEAR_W-1:0]  year,
  input  logic [MONTH_W-1:0] month,
  input  logic [DAY_W-1:0]   day,
  input  logic [YEAR_W-1:0]  lowest_year,
  input  logic [YEAR_W-1:0]  current_year,
  output lane_res_t          res
);

  logic signed [14:0] y_s;
  logic [13:0]        y_pos;
  logic [24:0]        prod100;
  logic [22:0]        prod400;
  logic [26:0]        prod25;

  logic [YEAR_W-1:0]        s1_year;
  logic [MONTH_W-1:0]       s1_month;
  logic [DAY_W-1:0]         s1_day;
  logic signed [DNUM_W-1:0] s1_p365;
  logic [11:0]              s1_q4;
  logic [7:0]               s1_q100;
  logic [5:0]               s1_q400;
  logic [9:0]               s1_q25;

  logic                     div4, div16, div25, leap;
  logic [DAY_W-1:0]         len;
  logic [STAT_W-1:0]        status_next;
  logic signed [DNUM_W-1:0] dnum_next;

  // stage 1: shifted year, products and quotients
  always_comb begin
    y_s = (month < 4'd3) ? $signed({1'b0, year}) - 15'sd1 : $signed({1'b0, year});
    y_pos = y_s[14] ? 14'd0 : y_s[13:0];
    prod100 = 25'(y_pos[13:2]) * 25'(RECIP_25);
    prod400 = 23'(y_pos[13:4]) * 23'(RECIP_25);
    prod25 = 27'(year) * 27'(RECIP_25);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_year <= year;
      s1_month <= month;
      s1_day <= day;
      s1_p365 <= $signed({{9{y_s[14]}}, y_s}) * 24'sd365;
      s1_q4 <= y_pos[13:2];
      s1_q100 <= prod100[RECIP_SHIFT+7:RECIP_SHIFT];
      s1_q400 <= prod400[RECIP_SHIFT+5:RECIP_SHIFT];
      s1_q25 <= prod25[RECIP_SHIFT+9:RECIP_SHIFT];
    end
  end

  // stage 2: checks and day number sum
  always_comb begin
    div4 = (s1_year[1:0] == 2'd0);
    div16 = (s1_year[3:0] == 4'd0);
    div25 = ((14'(s1_q25) * 14'd25) == s1_year);
    leap = (div4 && !div25) || (div16 && div25);
    len = month_len(s1_month) + {4'd0, (s1_month == 4'd2) && leap};
    if (({1'b0, s1_year} < {1'b0, lowest_year}) ||
        ({1'b0, s1_year} > ({1'b0, current_year} + 15'd1))) begin
      status_next = STAT_YEAR;
    end else if (s1_month < 4'd1 || s1_month > 4'd12) begin
      status_next = STAT_MONTH;
    end else if (s1_day < 5'd1 || s1_day > len) begin
      status_next = STAT_DAY;
    end else begin
      status_next = STAT_OK;
    end
    dnum_next = s1_p365 + $signed({12'd0, s1_q4}) - $signed({16'd0, s1_q100})
              + $signed({18'd0, s1_q400}) + $signed({15'd0, month_offset(s1_month)})
              + $signed({19'd0, s1_day}) - 24'sd306;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.status <= status_next;
      res.dnum <= dnum_next;
    end
  end

endmodule

### rtl/dvdd_merge.sv
// Merge stage: difference of the two lane day numbers and ordering flags.
// Depends on dvdd_pkg.
module dvdd_merge import dvdd_pkg::*; (
  input  logic                         clk,
  input  logic                         en,
  input  lane_res_t                    res_a,
  input  lane_res_t                    res_b,
  output logic [STAT_W-1:0]            status_a,
  output logic [STAT_W-1:0]            status_b,
  output logic signed [OUT_DIFF_W-1:0] day_difference,
  output logic                         a_before_b,
  output logic                         a_same_as_b,
  output logic                         a_after_b
);

  logic signed [DIFF_W-1:0] diff;

  assign diff = DIFF_W'(res_a.dnum) - DIFF_W'(res_b.dnum);

  always_ff @(posedge clk) begin
    if (en) begin
      status_a <= res_a.status;
      status_b <= res_b.status;
      day_difference <= diff[OUT_DIFF_W-1:0];
      a_before_b <= diff[DIFF_W-1];
      a_same_as_b <= (diff == '0);
      a_after_b <= !diff[DIFF_W-1] && (diff != '0);
    end
  end

endmodule

### rtl/date_validate_and_day_difference.sv
// Top level: config registers, two date lanes, merge stage and valid pipeline.
// Depends on dvdd_pkg, dvdd_lane, dvdd_merge.
//
// Usage:
//   Input channel (in_valid/in_ready) carries two dates A and B per transaction.
//   Output channel (out_valid/out_ready) returns per-date status, the A minus B
//   day difference and before/same/after flags, one transaction per input.
//   Config: write_enable with reg_index 0 (lowest valid year) or 1 (current_year)
//   and write_data; the user must write only while idle (not enforced).
//   Pipeline: three register stages (two in each lane, one merge), the first
//   loaded at acceptance; out_valid is registered with the merge stage.
//   Throughput: one transaction per cycle; both dates run in parallel lanes and
//   every stage advances each cycle the output register is free or taken.
//   Stall: while out_valid is high and out_ready low the whole pipeline holds
//   and in_ready drops; in_ready follows out_ready in the same cycle.
//   Reset: synchronous, clears the pipeline valids and loads the lowest valid
//   year 1500 and current_year 2023.
module date_validate_and_day_difference import dvdd_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [YEAR_W-1:0]            year_a,
  input  logic [MONTH_W-1:0]           month_a,
  input  logic [DAY_W-1:0]             day_a,
  input  logic [YEAR_W-1:0]            year_b,
  input  logic [MONTH_W-1:0]           month_b,
  input  logic [DAY_W-1:0]             day_b,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [STAT_W-1:0]            status_a,
  output logic [STAT_W-1:0]            status_b,
  output logic signed [OUT_DIFF_W-1:0] day_difference,
  output logic                         a_before_b,
  output logic                         a_same_as_b,
  output logic                         a_after_b,
  input  logic                         write_enable,
  input  logic [CFG_IDX_W-1:0]         reg_index,
  input  logic [YEAR_W-1:0]            write_data
);

  logic [YEAR_W-1:0] lowest_year;
  logic [YEAR_W-1:0] current_year;
  logic              en;
  logic              v1, v2;
  lane_res_t         res_a, res_b;

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      lowest_year <= LOWEST_YEAR_RST;
      current_year <= CURRENT_YEAR_RST;
    end else if (write_enable) begin
      case (reg_index)
        REG_LOWEST_YEAR:  lowest_year <= write_data;
        REG_CURRENT_YEAR: current_year <= write_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  dvdd_lane u_lane_a (
    .clk          (clk),
    .en           (en),
    .year         (year_a),
    .month        (month_a),
    .day          (day_a),
    .lowest_year  (lowest_year),
    .current_year (current_year),
    .res          (res_a)
  );

  dvdd_lane u_lane_b (
    .clk          (clk),
    .en           (en),
    .year         (year_b),
    .month        (month_b),
    .day          (day_b),
    .lowest_year  (lowest_year),
    .current_year (current_year),
    .res          (res_b)
  );

  dvdd_merge u_merge (
    .clk            (clk),
    .en             (en),
    .res_a          (res_a),
    .res_b          (res_b),
    .status_a       (status_a),
    .status_b       (status_b),
    .day_difference (day_difference),
    .a_before_b     (a_before_b),
    .a_same_as_b    (a_same_as_b),
    .a_after_b      (a_after_b)
  );

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot({a_before_b, a_same_as_b, a_after_b}))
    else $error("ordering flags not one-hot");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && a_same_as_b) |-> (day_difference == '0))
    else $error("equal dates with nonzero difference");

  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule
